[hw/rtl/bpr_pkg.sv]
`default_nettype none
package bpr_pkg;

  // Sizing of the search and of the arithmetic.
  localparam int MAX_STEPS  = 32;
  localparam int MAX_DEGREE = 6;
  localparam int FRAC_BITS  = 16;

  // At most 32 results per item, so the halving count never exceeds that.
  localparam int STEP_CAP   = (MAX_STEPS < 32) ? MAX_STEPS : 32;
  localparam int STEP_W     = $clog2(STEP_CAP + 1);
  localparam int IDX_W      = (MAX_DEGREE < 2) ? 1 : $clog2(MAX_DEGREE + 1);

  localparam int ADDR_W     = 5;

  typedef logic [31:0] word_t;
  typedef word_t [MAX_DEGREE:0] coef_arr_t;

  // Register map, by word index.
  typedef enum logic [2:0] {
    REG_DEGREE = 3'd0,
    REG_COEF0  = 3'd1,
    REG_COEF1  = 3'd2,
    REG_COEF2  = 3'd3,
    REG_COEF3  = 3'd4,
    REG_COEF4  = 3'd5,
    REG_COEF5  = 3'd6,
    REG_COEF6  = 3'd7
  } reg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ROW     = 2'd0,
    ST_NO_ROOT = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Clamp a signed 64-bit value to the signed 32-bit range.
  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bpr_regs.sv]
`default_nettype none
module bpr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bpr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [2:0]                 degree,
  output bpr_pkg::coef_arr_t              coef
);
  import bpr_pkg::*;

  logic [2:0] degree_r;
  coef_arr_t  coef_r;
  reg_idx_t   idx;
  logic       wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 3'd2;
      coef_r   <= '0;
    end else if (wr_en) begin
      if (idx == REG_DEGREE) begin
        degree_r <= pwdata[2:0];
      end else if (32'(idx) - 1 <= MAX_DEGREE) begin
        coef_r[IDX_W'(32'(idx) - 1)] <= pwdata;
      end
    end
  end

  // Every coefficient register reads back as written, whatever the degree.
  always_comb begin
    if (idx == REG_DEGREE) begin
      prdata = {29'd0, degree_r};
    end else if (32'(idx) - 1 <= MAX_DEGREE) begin
      prdata = coef_r[IDX_W'(32'(idx) - 1)];
    end else begin
      prdata = '0;
    end
  end

  assign degree = degree_r;
  assign coef   = coef_r;

endmodule
`default_nettype wire

[hw/rtl/bpr_horner.sv]
`default_nettype none
module bpr_horner (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] x,
  input  wire logic [2:0]         degree,
  input  wire bpr_pkg::coef_arr_t coef,
  output logic                    done,
  output logic signed [31:0]      value
);
  import bpr_pkg::*;

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_MUL  = 3'b010,
    H_ADD  = 3'b100
  } hstate_t;

  hstate_t            state_r, state_nxt;
  logic               done_r, done_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [IDX_W-1:0]   top_idx;
  logic signed [63:0] shifted;
  word_t              scaled;
  word_t              cadd;
  logic signed [63:0] sum;

  assign top_idx = (32'(degree) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(degree);
  assign shifted = prod_r >>> FRAC_BITS;
  assign scaled  = sat32(shifted);
  assign cadd    = coef[idx_r - 1'b1];
  assign sum     = $signed({{32{scaled[31]}}, scaled}) + $signed({{32{cadd[31]}}, cadd});

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    prod_nxt  = prod_r;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          acc_nxt = $signed(coef[top_idx]);
          idx_nxt = top_idx;
          x_nxt   = x;
          if (top_idx == '0) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = H_MUL;
          end
        end
      end
      H_MUL: begin
        prod_nxt  = 64'(acc_r) * 64'(x_r);
        state_nxt = H_ADD;
      end
      H_ADD: begin
        acc_nxt = $signed(sat32(sum));
        idx_nxt = idx_r - 1'b1;
        if (idx_r == IDX_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          state_nxt = H_MUL;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
  end

  assign done  = done_r;
  assign value = acc_r;

endmodule
`default_nettype wire

[hw/rtl/bisection_polynomial_root_top.sv]
`default_nettype none
// Bisection root search on a polynomial of degree up to six held in the
// configuration registers, all values signed Q16.16. An item is taken when
// start is high and busy is low, and it yields either one error result
// (status 2 for a bad interval or tolerance, status 1 when f has no strict
// sign change over the interval) or one table row per halving, the final
// result of every item carrying last. Each result appears for a single cycle
// under out_valid and cannot be held off, so the receiver must take it then.
// An invalid item is answered in the cycle after it is taken and leaves the
// block free. Every other item keeps busy high throughout: all evaluations
// go through one Horner unit with a single 32 by 32 multiplier, a multiply
// and then an add per degree, so the next item waits until this one's last
// result. Configuration may only be written while the block is idle.
module bisection_polynomial_root_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Request channel.
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [31:0]         in_interval_start,
  input  wire logic signed [31:0]         in_interval_end,
  input  wire logic signed [31:0]         in_tolerance,
  // Result channel.
  output logic                            out_valid,
  output logic [5:0]                      out_step_index,
  output logic signed [31:0]              out_lower_end,
  output logic signed [31:0]              out_upper_end,
  output logic signed [31:0]              out_midpoint,
  output logic signed [31:0]              out_value_at_lower,
  output logic signed [31:0]              out_value_at_upper,
  output logic signed [31:0]              out_value_at_mid,
  output logic                            out_root_in_lower_half,
  output logic [1:0]                      out_status,
  output logic                            out_last,
  // Configuration port.
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bpr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import bpr_pkg::*;

  // Sequencer states: evaluate both ends, check the sign change, work out
  // the number of halvings, then evaluate one midpoint per halving.
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EVAL_LO  = 6'b000010,
    S_EVAL_HI  = 6'b000100,
    S_CHECK    = 6'b001000,
    S_COUNT    = 6'b010000,
    S_EVAL_MID = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;

  // Working interval and the polynomial values at its ends.
  logic signed [31:0] cur_lower_r, cur_lower_nxt;
  logic signed [31:0] cur_upper_r, cur_upper_nxt;
  logic signed [31:0] val_lower_r, val_lower_nxt;
  logic signed [31:0] val_upper_r, val_upper_nxt;
  logic signed [31:0] mid_r, mid_nxt;

  // Halving count: the tolerance is doubled until it covers the width.
  logic [33:0]        tol_r, tol_nxt;
  logic [31:0]        width_r, width_nxt;
  logic [STEP_W-1:0]  k_r, k_nxt;
  logic [STEP_W-1:0]  steps_left_r, steps_left_nxt;
  logic [STEP_W-1:0]  step_idx_r, step_idx_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [5:0]         step_index_r, step_index_nxt;
  logic signed [31:0] o_lower_r, o_lower_nxt;
  logic signed [31:0] o_upper_r, o_upper_nxt;
  logic signed [31:0] o_mid_r, o_mid_nxt;
  logic signed [31:0] o_vlo_r, o_vlo_nxt;
  logic signed [31:0] o_vhi_r, o_vhi_nxt;
  logic signed [31:0] o_vmid_r, o_vmid_nxt;
  logic               o_flag_r, o_flag_nxt;
  status_t            o_status_r, o_status_nxt;
  logic               o_last_r, o_last_nxt;

  // Shared evaluator and the configuration registers.
  logic               hrn_start;
  logic signed [31:0] hrn_x;
  logic               hrn_done;
  logic signed [31:0] hrn_value;
  logic [2:0]         degree;
  coef_arr_t          coef;

  logic               accept;
  logic               bad_item;
  logic signed [32:0] span;
  logic signed [32:0] mid_sum;
  logic signed [31:0] first_mid;
  logic               flag;
  logic signed [31:0] nl, nu;
  logic signed [32:0] next_sum;
  logic               ends_opposite;

  bpr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .degree  (degree),
    .coef    (coef)
  );

  bpr_horner u_horner (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hrn_start),
    .x      (hrn_x),
    .degree (degree),
    .coef   (coef),
    .done   (hrn_done),
    .value  (hrn_value)
  );

  assign busy     = (state_r != S_IDLE);
  assign accept   = start & ~busy;
  assign bad_item = (in_interval_end <= in_interval_start) || (in_tolerance <= 32'sd0);
  assign span     = {cur_upper_r[31], cur_upper_r} - {cur_lower_r[31], cur_lower_r};

  // Midpoints are taken over a 33-bit sum so that they cannot overflow, and
  // the arithmetic shift rounds towards minus infinity.
  assign mid_sum   = {cur_lower_r[31], cur_lower_r} + {cur_upper_r[31], cur_upper_r};
  assign first_mid = mid_sum[32:1];

  assign ends_opposite = ((val_lower_r < 0) && (val_upper_r > 0)) ||
                         ((val_lower_r > 0) && (val_upper_r < 0));
  assign flag = ((val_lower_r < 0) && (hrn_value > 0)) ||
                ((val_lower_r > 0) && (hrn_value < 0));

  // Interval after the current halving, used to start the next one at once.
  assign nl       = flag ? cur_lower_r : mid_r;
  assign nu       = flag ? mid_r : cur_upper_r;
  assign next_sum = {nl[31], nl} + {nu[31], nu};

  always_comb begin
    state_nxt      = state_r;
    cur_lower_nxt  = cur_lower_r;
    cur_upper_nxt  = cur_upper_r;
    val_lower_nxt  = val_lower_r;
    val_upper_nxt  = val_upper_r;
    mid_nxt        = mid_r;
    tol_nxt        = tol_r;
    width_nxt      = width_r;
    k_nxt          = k_r;
    steps_left_nxt = steps_left_r;
    step_idx_nxt   = step_idx_r;
    out_valid_nxt  = 1'b0;
    step_index_nxt = step_index_r;
    o_lower_nxt    = o_lower_r;
    o_upper_nxt    = o_upper_r;
    o_mid_nxt      = o_mid_r;
    o_vlo_nxt      = o_vlo_r;
    o_vhi_nxt      = o_vhi_r;
    o_vmid_nxt     = o_vmid_r;
    o_flag_nxt     = o_flag_r;
    o_status_nxt   = o_status_r;
    o_last_nxt     = o_last_r;
    hrn_start      = 1'b0;
    hrn_x          = in_interval_start;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (bad_item) begin
            // Rejected at once: a single invalid result echoing the ends.
            out_valid_nxt  = 1'b1;
            step_index_nxt = '0;
            o_lower_nxt    = in_interval_start;
            o_upper_nxt    = in_interval_end;
            o_mid_nxt      = '0;
            o_vlo_nxt      = '0;
            o_vhi_nxt      = '0;
            o_vmid_nxt     = '0;
            o_flag_nxt     = 1'b0;
            o_status_nxt   = ST_INVALID;
            o_last_nxt     = 1'b1;
          end else begin
            cur_lower_nxt = in_interval_start;
            cur_upper_nxt = in_interval_end;
            tol_nxt       = {2'b00, in_tolerance};
            hrn_start     = 1'b1;
            hrn_x         = in_interval_start;
            state_nxt     = S_EVAL_LO;
          end
        end
      end

      S_EVAL_LO: begin
        if (hrn_done) begin
          val_lower_nxt = hrn_value;
          hrn_start     = 1'b1;
          hrn_x         = cur_upper_r;
          state_nxt     = S_EVAL_HI;
        end
      end

      S_EVAL_HI: begin
        if (hrn_done) begin
          val_upper_nxt = hrn_value;
          state_nxt     = S_CHECK;
        end
      end

      S_CHECK: begin
        if (!ends_opposite) begin
          // No strict sign change: report the ends and their values.
          out_valid_nxt  = 1'b1;
          step_index_nxt = '0;
          o_lower_nxt    = cur_lower_r;
          o_upper_nxt    = cur_upper_r;
          o_mid_nxt      = '0;
          o_vlo_nxt      = val_lower_r;
          o_vhi_nxt      = val_upper_r;
          o_vmid_nxt     = '0;
          o_flag_nxt     = 1'b0;
          o_status_nxt   = ST_NO_ROOT;
          o_last_nxt     = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          width_nxt = span[31:0];
          k_nxt     = '0;
          state_nxt = S_COUNT;
        end
      end

      S_COUNT: begin
        if ((tol_r < {2'b00, width_r}) && (32'(k_r) < STEP_CAP)) begin
          tol_nxt = {tol_r[32:0], 1'b0};
          k_nxt   = k_r + 1'b1;
        end else begin
          // At least one halving is always made.
          steps_left_nxt = (k_r == '0) ? STEP_W'(1) : k_r;
          step_idx_nxt   = '0;
          mid_nxt        = first_mid;
          hrn_start      = 1'b1;
          hrn_x          = first_mid;
          state_nxt      = S_EVAL_MID;
        end
      end

      S_EVAL_MID: begin
        if (hrn_done) begin
          out_valid_nxt  = 1'b1;
          step_index_nxt = 6'(step_idx_r) + 6'd1;
          o_lower_nxt    = cur_lower_r;
          o_upper_nxt    = cur_upper_r;
          o_mid_nxt      = mid_r;
          o_vlo_nxt      = val_lower_r;
          o_vhi_nxt      = val_upper_r;
          o_vmid_nxt     = hrn_value;
          o_flag_nxt     = flag;
          o_status_nxt   = ST_ROW;
          o_last_nxt     = (steps_left_r == STEP_W'(1));

          // The half that keeps the sign change survives.
          if (flag) begin
            cur_upper_nxt = mid_r;
            val_upper_nxt = hrn_value;
          end else begin
            cur_lower_nxt = mid_r;
            val_lower_nxt = hrn_value;
          end
          steps_left_nxt = steps_left_r - 1'b1;
          step_idx_nxt   = step_idx_r + 1'b1;

          if (steps_left_r == STEP_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            mid_nxt   = next_sum[32:1];
            hrn_start = 1'b1;
            hrn_x     = next_sum[32:1];
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_lower_r  <= cur_lower_nxt;
    cur_upper_r  <= cur_upper_nxt;
    val_lower_r  <= val_lower_nxt;
    val_upper_r  <= val_upper_nxt;
    mid_r        <= mid_nxt;
    tol_r        <= tol_nxt;
    width_r      <= width_nxt;
    k_r          <= k_nxt;
    steps_left_r <= steps_left_nxt;
    step_idx_r   <= step_idx_nxt;
    step_index_r <= step_index_nxt;
    o_lower_r    <= o_lower_nxt;
    o_upper_r    <= o_upper_nxt;
    o_mid_r      <= o_mid_nxt;
    o_vlo_r      <= o_vlo_nxt;
    o_vhi_r      <= o_vhi_nxt;
    o_vmid_r     <= o_vmid_nxt;
    o_flag_r     <= o_flag_nxt;
    o_status_r   <= o_status_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_step_index         = step_index_r;
  assign out_lower_end          = o_lower_r;
  assign out_upper_end          = o_upper_r;
  assign out_midpoint           = o_mid_r;
  assign out_value_at_lower     = o_vlo_r;
  assign out_value_at_upper     = o_vhi_r;
  assign out_value_at_mid       = o_vmid_r;
  assign out_root_in_lower_half = o_flag_r;
  assign out_status             = o_status_r;
  assign out_last               = o_last_r;

endmodule
`default_nettype wire

[tb/bisection_polynomial_root_top_test.sv]
`default_nettype none
// Self-checking bench for the bisection root search.
//
// The bench keeps its own copy of the degree and coefficient registers and
// works out, for every item the block takes, the full list of results that
// the item should produce: one error result, or one table row per halving.
// Those rows wait in a queue, and a checking process compares every strobed
// result against the oldest of them, field by field.
//
// Configuration is written through the register port only while the block is
// idle, that is once every expected result has come back and busy has fallen.
module bisection_polynomial_root_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpr_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam int     ONE      = 1 << FRAC_BITS;

  // One expected result, held at the widths of the result ports.
  typedef struct {
    logic [5:0] step_index;
    word_t      lower_end;
    word_t      upper_end;
    word_t      midpoint;
    word_t      value_at_lower;
    word_t      value_at_upper;
    word_t      value_at_mid;
    logic       root_in_lower_half;
    status_t    status;
    logic       last;
  } search_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_interval_start = '0;
  logic signed [31:0] in_interval_end = '0;
  logic signed [31:0] in_tolerance = '0;

  logic               out_valid;
  logic [5:0]         out_step_index;
  logic signed [31:0] out_lower_end;
  logic signed [31:0] out_upper_end;
  logic signed [31:0] out_midpoint;
  logic signed [31:0] out_value_at_lower;
  logic signed [31:0] out_value_at_upper;
  logic signed [31:0] out_value_at_mid;
  logic               out_root_in_lower_half;
  logic [1:0]         out_status;
  logic               out_last;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Mirror of the configuration registers as the block should hold them.
  logic [2:0] degree_mirror = 3'd2;
  int         coef_mirror [7] = '{default: 0};

  // Rows still owed by the block, oldest first.
  search_row_t pending_rows [$];

  int mismatches = 0;
  // Chance, in percent, that the sender holds back before raising start.
  int sender_idle_pct = 19;

  bisection_polynomial_root_top uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_interval_start      (in_interval_start),
    .in_interval_end        (in_interval_end),
    .in_tolerance           (in_tolerance),
    .out_valid              (out_valid),
    .out_step_index         (out_step_index),
    .out_lower_end          (out_lower_end),
    .out_upper_end          (out_upper_end),
    .out_midpoint           (out_midpoint),
    .out_value_at_lower     (out_value_at_lower),
    .out_value_at_upper     (out_value_at_upper),
    .out_value_at_mid       (out_value_at_mid),
    .out_root_in_lower_half (out_root_in_lower_half),
    .out_status             (out_status),
    .out_last               (out_last),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Arithmetic of the search, at the block's own widths.
  // ---------------------------------------------------------------------

  function automatic int clamp_word(input longint v);
    if (v > WORD_MAX) begin
      return int'(WORD_MAX);
    end else if (v < WORD_MIN) begin
      return int'(WORD_MIN);
    end
    return int'(v);
  endfunction

  function automatic int sign_of(input int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Horner evaluation from the top coefficient down. The product is exact in
  // 64 bits and the shift rounds towards minus infinity; both the product and
  // the sum are clamped to the 32-bit range. A degree of seven is treated as
  // the largest degree the block supports.
  function automatic int eval_poly(input int x);
    int     d;
    int     acc;
    longint prod;
    d = (int'(degree_mirror) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_mirror);
    acc = coef_mirror[d];
    while (d > 0) begin
      d--;
      prod = (longint'(acc) * longint'(x)) >>> FRAC_BITS;
      acc = clamp_word(prod);
      acc = clamp_word(longint'(acc) + longint'(coef_mirror[d]));
    end
    return acc;
  endfunction

  // Works out every result that one accepted item should produce and queues
  // them in order.
  task automatic predict_search(input int a, input int b, input int tol);
    search_row_t row;
    int          lo, hi, mid, f_lo, f_hi, f_mid, halvings;
    longint      width, reach;
    row = '{step_index: '0, lower_end: a, upper_end: b, midpoint: '0,
            value_at_lower: '0, value_at_upper: '0, value_at_mid: '0,
            root_in_lower_half: 1'b0, status: ST_INVALID, last: 1'b1};
    if (b <= a || tol <= 0) begin
      pending_rows.push_back(row);
      return;
    end
    f_lo = eval_poly(a);
    f_hi = eval_poly(b);
    if (sign_of(f_lo) * sign_of(f_hi) >= 0) begin
      row.status = ST_NO_ROOT;
      row.value_at_lower = f_lo;
      row.value_at_upper = f_hi;
      pending_rows.push_back(row);
      return;
    end
    // Smallest number of halvings that brings the width within tolerance,
    // at least one and never more than the step cap.
    width = longint'(b) - longint'(a);
    reach = longint'(tol);
    halvings = 0;
    while (reach < width && halvings < STEP_CAP) begin
      reach = reach << 1;
      halvings++;
    end
    if (halvings < 1) halvings = 1;
    lo = a;
    hi = b;
    for (int n = 1; n <= halvings; n++) begin
      mid = int'((longint'(lo) + longint'(hi)) >>> 1);
      f_mid = eval_poly(mid);
      row.step_index = 6'(n);
      row.lower_end = lo;
      row.upper_end = hi;
      row.midpoint = mid;
      row.value_at_lower = f_lo;
      row.value_at_upper = f_hi;
      row.value_at_mid = f_mid;
      row.root_in_lower_half = (sign_of(f_lo) * sign_of(f_mid) < 0);
      row.status = ST_ROW;
      row.last = (n == halvings);
      pending_rows.push_back(row);
      if (row.root_in_lower_half) begin
        hi = mid;
        f_hi = f_mid;
      end else begin
        lo = mid;
        f_lo = f_mid;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking of results.
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // A result is on the ports for exactly the cycle that ends at this edge,
  // so it is taken here, with the values as they stood before the edge.
  always @(posedge clk) begin : check_results
    search_row_t want;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid unknown", 32'(out_valid), 32'd0);
      end else if (out_valid) begin
        if (pending_rows.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_lower_end, 32'd0);
        end else begin
          want = pending_rows.pop_front();
          if (out_step_index !== want.step_index)
            report_mismatch("step_index", 32'(out_step_index), 32'(want.step_index));
          if (out_lower_end !== want.lower_end)
            report_mismatch("lower_end", out_lower_end, want.lower_end);
          if (out_upper_end !== want.upper_end)
            report_mismatch("upper_end", out_upper_end, want.upper_end);
          if (out_midpoint !== want.midpoint)
            report_mismatch("midpoint", out_midpoint, want.midpoint);
          if (out_value_at_lower !== want.value_at_lower)
            report_mismatch("value_at_lower", out_value_at_lower, want.value_at_lower);
          if (out_value_at_upper !== want.value_at_upper)
            report_mismatch("value_at_upper", out_value_at_upper, want.value_at_upper);
          if (out_value_at_mid !== want.value_at_mid)
            report_mismatch("value_at_mid", out_value_at_mid, want.value_at_mid);
          if (out_root_in_lower_half !== want.root_in_lower_half)
            report_mismatch("root_in_lower_half", 32'(out_root_in_lower_half),
                            32'(want.root_in_lower_half));
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving of the block.
  // ---------------------------------------------------------------------

  // Sends one item. Start is left high once the item has been taken: if the
  // next item follows straight away it simply keeps start up with new values,
  // and anything else that lets time pass lowers start first. That way start
  // never gets two assignments in the same time step.
  task automatic send_request(input int a, input int b, input int tol);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) begin
      // Mostly short pauses, now and then a much longer one.
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_interval_start <= a;
    in_interval_end <= b;
    in_tolerance <= tol;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_search(a, b, tol);
  endtask

  // Lowers start and holds the sender back until every outstanding result has
  // come and busy has fallen.
  task automatic wait_until_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: a setup cycle, then an access cycle that completes
  // at the edge where pready is seen high. The bus is then left idle.
  task automatic write_register(input reg_idx_t idx, input word_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_DEGREE) begin
      degree_mirror = value[2:0];
    end else begin
      coef_mirror[int'(idx) - int'(REG_COEF0)] = value;
    end
  endtask

  function automatic word_t random_coefficient();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return ($urandom_range(1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2:       return '0;
      default: return word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // Draws a fresh polynomial and writes every register.
  task automatic load_random_polynomial();
    logic [2:0] deg;
    deg = ($urandom_range(5) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    write_register(REG_DEGREE, word_t'(deg));
    for (int i = 0; i < 7; i++) begin
      write_register(reg_idx_t'(int'(REG_COEF0) + i), random_coefficient());
    end
  endtask

  // A well-formed request: random intervals at random scales are tried until
  // the current polynomial changes sign over one, or forty have been tried,
  // and a tolerance that gives anything from one halving to the full count.
  task automatic send_bracketed_item();
    int     a, b, t, scale;
    longint width, tol;
    a = 0;
    b = 1;
    for (int tries = 0; tries < 40; tries++) begin
      scale = $urandom_range(4, 31);
      a = int'($urandom) >>> (31 - scale);
      b = int'($urandom) >>> (31 - scale);
      if (b < a) begin
        t = a;
        a = b;
        b = t;
      end
      if (a == b) begin
        if (a != int'(WORD_MAX)) b = a + 1;
        else a = a - 1;
      end
      if (sign_of(eval_poly(a)) * sign_of(eval_poly(b)) < 0) break;
    end
    width = longint'(b) - longint'(a);
    tol = width >>> $urandom_range(0, 33);
    if ($urandom_range(7) == 0) tol = $urandom_range(1, 16);
    if (tol < 1) tol = 1;
    if (tol > WORD_MAX) tol = WORD_MAX;
    send_request(a, b, int'(tol));
  endtask

  // Requests that mostly fail the checks: any bit pattern, empty or reversed
  // intervals, and tolerances that are zero or negative.
  task automatic send_noise_item();
    int a, b, t;
    a = $urandom;
    b = $urandom;
    t = $urandom;
    case ($urandom_range(4))
      0: ;
      1: b = a;
      2: begin
        if (b < a) begin
          b = a ^ b;
          a = a ^ b;
          b = a ^ b;
        end
        t = ($urandom_range(1) == 0) ? 0 : (t | 32'h8000_0000);
      end
      3: begin
        if (b > a) begin
          b = a ^ b;
          a = a ^ b;
          b = a ^ b;
        end
      end
      default: begin
        if (b < a) begin
          b = a ^ b;
          a = a ^ b;
          b = a ^ b;
        end
        t = t & 32'h7FFF_FFFF;
      end
    endcase
    send_request(a, b, t);
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Out of reset the polynomial is identically zero, so a good interval
  // still finds no sign change, and both values come back as zero.
  task automatic check_reset_state();
    send_request(0, ONE, 1);
  endtask

  // Empty and reversed intervals, and tolerances of zero or below.
  task automatic check_invalid_requests();
    send_request(ONE, ONE, ONE);
    send_request(int'(WORD_MAX), int'(WORD_MIN), 1);
    send_request(0, ONE, 0);
    send_request(0, ONE, int'(WORD_MIN));
    send_request(int'(WORD_MIN), int'(WORD_MAX), -1);
  endtask

  // x squared minus two: a long search, a tolerance wider than the interval
  // (which still gives one halving), and a half-range interval whose far end
  // saturates.
  task automatic check_square_root_of_two();
    wait_until_idle();
    write_register(REG_COEF0, word_t'(-2 * ONE));
    write_register(REG_COEF1, '0);
    write_register(REG_COEF2, word_t'(ONE));
    write_register(REG_DEGREE, 32'd2);
    send_request(0, 2 * ONE, 1);
    send_request(0, 2 * ONE, int'(WORD_MAX));
    send_request(int'(WORD_MIN), 0, 1);
    send_request(ONE, 2 * ONE, ONE >> 4);
  endtask

  // f(x) = x: the full signed range hits the step cap, a zero at either end
  // counts as no sign change, a midpoint that lands on the root is not a
  // sign change either, and a negative odd sum rounds towards minus infinity.
  task automatic check_linear_edge_cases();
    wait_until_idle();
    write_register(REG_DEGREE, 32'd1);
    write_register(REG_COEF0, '0);
    write_register(REG_COEF1, word_t'(ONE));
    write_register(REG_COEF2, '0);
    send_request(int'(WORD_MIN), int'(WORD_MAX), 1);
    send_request(0, 5 * ONE, 1);
    send_request(-5 * ONE, 0, 1);
    send_request(-1, 2, 1);
    send_request(-3, 2, 1);
  endtask

  // Extreme coefficients with degree seven, which the block treats as six,
  // so that products and sums clamp at both ends of the range.
  task automatic check_saturation_and_degree_clamp();
    wait_until_idle();
    write_register(REG_DEGREE, 32'd7);
    write_register(REG_COEF0, 32'h8000_0000);
    write_register(REG_COEF1, '0);
    write_register(REG_COEF2, '0);
    write_register(REG_COEF3, 32'h7FFF_FFFF);
    write_register(REG_COEF4, '0);
    write_register(REG_COEF5, 32'h8000_0000);
    write_register(REG_COEF6, 32'h7FFF_FFFF);
    send_request(0, int'(WORD_MAX), ONE);
    send_request(int'(WORD_MIN), 0, ONE);
    send_request(int'(WORD_MIN), int'(WORD_MAX), int'(WORD_MAX));
  endtask

  // Degree zero: a constant never changes sign.
  task automatic check_constant_polynomial();
    wait_until_idle();
    write_register(REG_DEGREE, 32'd0);
    write_register(REG_COEF0, word_t'(3 * ONE));
    send_request(-ONE, ONE, 1);
    send_request(int'(WORD_MIN), int'(WORD_MAX), 1);
  endtask

  // Random items at one sender idling rate. The polynomial is redrawn every
  // fifteen items, which also makes the sender wait for every outstanding
  // result at those points.
  task automatic run_random_phase(input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 15 == 0) begin
        wait_until_idle();
        load_random_polynomial();
      end
      if ($urandom_range(99) < 80) send_bracketed_item();
      else send_noise_item();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    sender_idle_pct = 19;
    check_reset_state();
    check_invalid_requests();
    check_square_root_of_two();
    check_linear_edge_cases();
    check_saturation_and_degree_clamp();
    check_constant_polynomial();

    run_random_phase(19, 37);
    run_random_phase(46, 37);
    run_random_phase(0, 37);

    wait_until_idle();
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The slowest correct run is well under two milliseconds of simulated
  // time, so this only fires when the block hangs.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
